>>> src/iprx_pkg.sv
// Shared types and constants for the IPv4 receive header filter.
`timescale 1ns / 1ps

package iprx_pkg;

    localparam int WORD_W  = 16;
    localparam int ADDR_W  = 32;
    localparam int PROTO_W = 8;
    localparam int COUNT_W = 5;
    localparam int NIB_W   = 4;

    localparam logic [ADDR_W-1:0]  LOCAL_ADDRESS_RESET = 32'hC0A8_0064;
    localparam logic [ADDR_W-1:0]  BCAST_ADDRESS       = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0]  CSUM_GOOD           = 16'hFFFF;
    localparam logic [NIB_W-1:0]   IP_VERSION          = 4'd4;
    localparam logic [NIB_W-1:0]   MIN_IHL             = 4'd5;
    localparam logic [PROTO_W-1:0] PROTO_ICMP          = 8'd1;
    localparam logic [PROTO_W-1:0] PROTO_TCP           = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP           = 8'd17;

    // Word positions inside the header, counted from the first word as zero.
    localparam logic [COUNT_W-1:0] POS_LENGTH   = 5'd1;
    localparam logic [COUNT_W-1:0] POS_PROTOCOL = 5'd4;
    localparam logic [COUNT_W-1:0] POS_DEST_HI  = 5'd8;
    localparam logic [COUNT_W-1:0] POS_DEST_LO  = 5'd9;

    typedef enum logic [2:0] {
        VERDICT_ICMP      = 3'd0,
        VERDICT_UDP       = 3'd1,
        VERDICT_TCP       = 3'd2,
        VERDICT_OTHER     = 3'd3,
        VERDICT_VERSION   = 3'd4,
        VERDICT_NOT_OURS  = 3'd5,
        VERDICT_CHECKSUM  = 3'd6,
        VERDICT_MALFORMED = 3'd7
    } verdict_t;

    typedef struct packed {
        logic [WORD_W-1:0] header_word;
        logic              first_word;
    } word_beat_t;

    typedef struct packed {
        verdict_t           verdict;
        logic [WORD_W-1:0]  total_length;
        logic [PROTO_W-1:0] protocol_number;
    } result_t;

endpackage

>>> src/iprx_word_if.sv
// Stream interface that carries header word beats.
`timescale 1ns / 1ps

interface iprx_word_if;
    logic                         valid;
    logic                         ready;
    logic [iprx_pkg::WORD_W-1:0]  header_word;
    logic                         first_word;

    modport source (output valid, output header_word, output first_word, input ready);
    modport sink   (input valid, input header_word, input first_word, output ready);
endinterface

>>> src/iprx_verdict_if.sv
// Stream interface that carries verdict beats.
`timescale 1ns / 1ps

interface iprx_verdict_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    verdict;
    logic [iprx_pkg::WORD_W-1:0]   total_length;
    logic [iprx_pkg::PROTO_W-1:0]  protocol_number;

    modport source (output valid, output verdict, output total_length,
                    output protocol_number, input ready);
    modport sink   (input valid, input verdict, input total_length,
                    input protocol_number, output ready);
endinterface

>>> src/ipv4_rx_header_filter.sv
// Path: a word beat passes the input register and the parser; any verdict it yields is held in the output register.
// Throughput: one header word per cycle; the input register and the output
// register each pass a beat on in every cycle the downstream side takes one.
// Reset: rst_n clears the parser state to idle, empties both registers and
// sets the local address to 192.168.0.100.
`timescale 1ns / 1ps

module ipv4_rx_header_filter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [iprx_pkg::ADDR_W-1:0]  cfg_wdata,
    iprx_word_if.sink                    words,
    iprx_verdict_if.source               verdicts
);

    logic [iprx_pkg::ADDR_W-1:0] local_address_reg;
    logic                        beat_valid;
    iprx_pkg::word_beat_t        beat;
    logic                        take;
    logic                        advance;
    logic                        res_valid;
    iprx_pkg::result_t           res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg <= iprx_pkg::LOCAL_ADDRESS_RESET;
        end
        else if (cfg_we)
        begin
            local_address_reg <= cfg_wdata;
        end
    end

    assign advance = beat_valid && take;

    iprx_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .words      (words),
        .take       (take),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    iprx_hdr_parse u_hdr_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .local_address (local_address_reg),
        .item_valid    (advance),
        .item          (beat),
        .res_valid     (res_valid),
        .res           (res)
    );

    iprx_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .verdicts  (verdicts),
        .take      (take)
    );

`ifndef SYNTHESIS
    a_malformed_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        verdicts.valid && verdicts.verdict == iprx_pkg::VERDICT_MALFORMED
        |-> verdicts.total_length == '0 && verdicts.protocol_number == '0)
        else $error("Malformed verdict carries nonzero fields.");

    a_icmp_protocol: assert property (@(posedge clk) disable iff (!rst_n)
        verdicts.valid && verdicts.verdict == iprx_pkg::VERDICT_ICMP
        |-> verdicts.protocol_number == iprx_pkg::PROTO_ICMP)
        else $error("ICMP verdict with another protocol number.");

    a_other_protocol: assert property (@(posedge clk) disable iff (!rst_n)
        verdicts.valid && verdicts.verdict == iprx_pkg::VERDICT_OTHER
        |-> verdicts.protocol_number != iprx_pkg::PROTO_ICMP
            && verdicts.protocol_number != iprx_pkg::PROTO_UDP
            && verdicts.protocol_number != iprx_pkg::PROTO_TCP)
        else $error("Other-protocol verdict for a known protocol.");

    a_result_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> advance)
        else $error("Parser produced a result without an input beat.");
`endif

endmodule

>>> src/iprx_in_stage.sv
// Input register that captures one header word beat.
`timescale 1ns / 1ps

module iprx_in_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    iprx_word_if.sink              words,
    input  logic                   take,
    output logic                   beat_valid,
    output iprx_pkg::word_beat_t   beat
);

    logic                  valid_reg;
    iprx_pkg::word_beat_t  beat_reg;

    assign words.ready = !valid_reg || take;
    assign beat_valid  = valid_reg;
    assign beat        = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (words.ready)
        begin
            valid_reg <= words.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (words.valid && words.ready)
        begin
            beat_reg.header_word <= words.header_word;
            beat_reg.first_word  <= words.first_word;
        end
    end

endmodule

>>> src/iprx_hdr_parse.sv
// Header parser: field capture, checksum accumulation and verdict decision.
`timescale 1ns / 1ps

module iprx_hdr_parse (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [iprx_pkg::ADDR_W-1:0]     local_address,
    input  logic                            item_valid,
    input  iprx_pkg::word_beat_t            item,
    output logic                            res_valid,
    output iprx_pkg::result_t               res
);

    logic                            in_header_reg,   in_header_next;
    logic [iprx_pkg::COUNT_W-1:0]    word_count_reg,  word_count_next;
    logic [iprx_pkg::COUNT_W-1:0]    header_words_reg, header_words_next;
    logic [iprx_pkg::WORD_W-1:0]     sum_reg,         sum_next;
    logic [iprx_pkg::NIB_W-1:0]      version_reg,     version_next;
    logic [iprx_pkg::WORD_W-1:0]     length_reg,      length_next;
    logic [iprx_pkg::PROTO_W-1:0]    protocol_reg,    protocol_next;
    logic [iprx_pkg::ADDR_W-1:0]     dest_reg,        dest_next;

    logic [iprx_pkg::NIB_W-1:0]      ihl;
    logic [iprx_pkg::WORD_W:0]       raw_sum;
    logic [iprx_pkg::WORD_W-1:0]     folded_sum;

    assign ihl        = item.header_word[11:8];
    assign raw_sum    = {1'b0, sum_reg} + {1'b0, item.header_word};
    assign folded_sum = raw_sum[iprx_pkg::WORD_W-1:0]
                      + {{(iprx_pkg::WORD_W-1){1'b0}}, raw_sum[iprx_pkg::WORD_W]};

    always_comb
    begin
        in_header_next    = in_header_reg;
        word_count_next   = word_count_reg;
        header_words_next = header_words_reg;
        sum_next          = sum_reg;
        version_next      = version_reg;
        length_next       = length_reg;
        protocol_next     = protocol_reg;
        dest_next         = dest_reg;
        res_valid         = 1'b0;
        res.verdict         = iprx_pkg::VERDICT_MALFORMED;
        res.total_length    = '0;
        res.protocol_number = '0;

        if (item_valid && item.first_word)
        begin
            version_next      = item.header_word[15:12];
            length_next       = '0;
            protocol_next     = '0;
            dest_next         = '0;
            sum_next          = item.header_word;
            word_count_next   = iprx_pkg::COUNT_W'(1);
            header_words_next = {ihl, 1'b0};
            if (ihl < iprx_pkg::MIN_IHL)
            begin
                in_header_next = 1'b0;
                res_valid      = 1'b1;
            end
            else
            begin
                in_header_next = 1'b1;
            end
        end
        else if (item_valid && in_header_reg)
        begin
            case (word_count_reg)
                iprx_pkg::POS_LENGTH:   length_next   = item.header_word;
                iprx_pkg::POS_PROTOCOL: protocol_next = item.header_word[7:0];
                iprx_pkg::POS_DEST_HI:  dest_next     = {item.header_word, dest_reg[15:0]};
                iprx_pkg::POS_DEST_LO:  dest_next     = {dest_reg[31:16], item.header_word};
                default:                ;
            endcase
            sum_next        = folded_sum;
            word_count_next = word_count_reg + iprx_pkg::COUNT_W'(1);

            if (word_count_next == header_words_reg)
            begin
                in_header_next      = 1'b0;
                res_valid           = 1'b1;
                res.total_length    = length_next;
                res.protocol_number = protocol_next;
                if (version_reg != iprx_pkg::IP_VERSION)
                begin
                    res.verdict = iprx_pkg::VERDICT_VERSION;
                end
                else if (dest_next != local_address && dest_next != iprx_pkg::BCAST_ADDRESS)
                begin
                    res.verdict = iprx_pkg::VERDICT_NOT_OURS;
                end
                else if (sum_next != iprx_pkg::CSUM_GOOD)
                begin
                    res.verdict = iprx_pkg::VERDICT_CHECKSUM;
                end
                else if (protocol_next == iprx_pkg::PROTO_ICMP)
                begin
                    res.verdict = iprx_pkg::VERDICT_ICMP;
                end
                else if (protocol_next == iprx_pkg::PROTO_UDP)
                begin
                    res.verdict = iprx_pkg::VERDICT_UDP;
                end
                else if (protocol_next == iprx_pkg::PROTO_TCP)
                begin
                    res.verdict = iprx_pkg::VERDICT_TCP;
                end
                else
                begin
                    res.verdict = iprx_pkg::VERDICT_OTHER;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_header_reg    <= 1'b0;
            word_count_reg   <= '0;
            header_words_reg <= '0;
            sum_reg          <= '0;
            version_reg      <= '0;
            length_reg       <= '0;
            protocol_reg     <= '0;
            dest_reg         <= '0;
        end
        else
        begin
            in_header_reg    <= in_header_next;
            word_count_reg   <= word_count_next;
            header_words_reg <= header_words_next;
            sum_reg          <= sum_next;
            version_reg      <= version_next;
            length_reg       <= length_next;
            protocol_reg     <= protocol_next;
            dest_reg         <= dest_next;
        end
    end

endmodule

>>> src/iprx_out_stage.sv
// Output register that holds one verdict beat until it is taken.
`timescale 1ns / 1ps

module iprx_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    input  iprx_pkg::result_t    res,
    iprx_verdict_if.source       verdicts,
    output logic                 take
);

    logic               valid_reg;
    iprx_pkg::result_t  res_reg;

    assign take                     = !valid_reg || verdicts.ready;
    assign verdicts.valid           = valid_reg;
    assign verdicts.verdict         = res_reg.verdict;
    assign verdicts.total_length    = res_reg.total_length;
    assign verdicts.protocol_number = res_reg.protocol_number;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for ipv4_rx_header_filter: random IPv4 headers in, verdicts checked.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_WORDS = 225;
    localparam int DRAIN_WAIT  = 4;
    localparam int REPORT_MAX  = 40;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [iprx_pkg::ADDR_W-1:0] cfg_wdata;

    iprx_word_if    words_if ();
    iprx_verdict_if verdicts_if ();

    ipv4_rx_header_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .words     (words_if),
        .verdicts  (verdicts_if)
    );

    iprx_pkg::word_beat_t pending_words [$];
    iprx_pkg::result_t    expected_verdicts [$];

    int cycle_count = 0;
    int mismatches = 0;
    int send_gap = 0;
    int recv_stall = 0;
    int hold_left = 0;
    int long_hold_asked = 0;
    int long_hold_done = 0;
    bit steady = 1'b0;

    logic [iprx_pkg::ADDR_W-1:0]  local_addr_model;
    logic [iprx_pkg::COUNT_W-1:0] parse_count;
    logic [iprx_pkg::COUNT_W-1:0] parse_words;
    logic [iprx_pkg::WORD_W-1:0]  csum_acc;
    logic [iprx_pkg::NIB_W-1:0]   version_nib;
    logic [iprx_pkg::WORD_W-1:0]  length_seen;
    logic [iprx_pkg::PROTO_W-1:0] proto_seen;
    logic [iprx_pkg::ADDR_W-1:0]  dest_seen;
    logic                         parsing;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [iprx_pkg::WORD_W-1:0] ones_add(
        input logic [iprx_pkg::WORD_W-1:0] a,
        input logic [iprx_pkg::WORD_W-1:0] b);
        logic [iprx_pkg::WORD_W:0] s;
        s = a + b;
        return s[iprx_pkg::WORD_W-1:0] + s[iprx_pkg::WORD_W];
    endfunction

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < REPORT_MAX)
            $display("cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    task automatic filter_word(input iprx_pkg::word_beat_t beat);
        iprx_pkg::result_t           r;
        logic [iprx_pkg::NIB_W-1:0]  ihl;
        logic [iprx_pkg::WORD_W-1:0] w;
        w = beat.header_word;
        if (beat.first_word)
        begin
            ihl         = w[11:8];
            version_nib = w[15:12];
            length_seen = '0;
            proto_seen  = '0;
            dest_seen   = '0;
            csum_acc    = w;
            parse_count = 5'd1;
            parse_words = {ihl, 1'b0};
            if (ihl < iprx_pkg::MIN_IHL)
            begin
                parsing           = 1'b0;
                r.verdict         = iprx_pkg::VERDICT_MALFORMED;
                r.total_length    = '0;
                r.protocol_number = '0;
                expected_verdicts.push_back(r);
            end
            else
                parsing = 1'b1;
        end
        else if (parsing)
        begin
            case (parse_count)
                iprx_pkg::POS_LENGTH:   length_seen = w;
                iprx_pkg::POS_PROTOCOL: proto_seen = w[7:0];
                iprx_pkg::POS_DEST_HI:  dest_seen[31:16] = w;
                iprx_pkg::POS_DEST_LO:  dest_seen[15:0] = w;
                default: ;
            endcase
            csum_acc    = ones_add(csum_acc, w);
            parse_count = parse_count + 5'd1;
            if (parse_count == parse_words)
            begin
                parsing = 1'b0;
                if (version_nib != iprx_pkg::IP_VERSION)
                    r.verdict = iprx_pkg::VERDICT_VERSION;
                else if (dest_seen != local_addr_model
                         && dest_seen != iprx_pkg::BCAST_ADDRESS)
                    r.verdict = iprx_pkg::VERDICT_NOT_OURS;
                else if (csum_acc != iprx_pkg::CSUM_GOOD)
                    r.verdict = iprx_pkg::VERDICT_CHECKSUM;
                else if (proto_seen == iprx_pkg::PROTO_ICMP)
                    r.verdict = iprx_pkg::VERDICT_ICMP;
                else if (proto_seen == iprx_pkg::PROTO_UDP)
                    r.verdict = iprx_pkg::VERDICT_UDP;
                else if (proto_seen == iprx_pkg::PROTO_TCP)
                    r.verdict = iprx_pkg::VERDICT_TCP;
                else
                    r.verdict = iprx_pkg::VERDICT_OTHER;
                r.total_length    = length_seen;
                r.protocol_number = proto_seen;
                expected_verdicts.push_back(r);
            end
        end
    endtask

    task automatic queue_beat(input logic [iprx_pkg::WORD_W-1:0] w, input logic first);
        iprx_pkg::word_beat_t beat;
        beat.header_word = w;
        beat.first_word  = first;
        pending_words.push_back(beat);
    endtask

    task automatic queue_header(input logic [iprx_pkg::NIB_W-1:0]   version,
                                input logic [iprx_pkg::NIB_W-1:0]   ihl,
                                input logic [iprx_pkg::PROTO_W-1:0] proto,
                                input logic [iprx_pkg::ADDR_W-1:0]  dest,
                                input bit good_csum, input int keep);
        logic [iprx_pkg::WORD_W-1:0] hdr [$];
        logic [iprx_pkg::WORD_W-1:0] sum;
        int n;
        n = int'(ihl) * 2;
        hdr.push_back({version, ihl, 8'($urandom)});
        hdr.push_back(16'($urandom));
        hdr.push_back(16'($urandom));
        hdr.push_back(16'($urandom));
        hdr.push_back({8'($urandom), proto});
        hdr.push_back(16'h0000);
        hdr.push_back(16'($urandom));
        hdr.push_back(16'($urandom));
        hdr.push_back(dest[31:16]);
        hdr.push_back(dest[15:0]);
        while (hdr.size() < n)
            hdr.push_back(16'($urandom));
        sum = hdr[0];
        for (int i = 1; i < n; i++)
            sum = ones_add(sum, hdr[i]);
        hdr[5] = good_csum ? ~sum : ~sum ^ (16'h1 << $urandom_range(0, 15));
        for (int i = 0; i < keep; i++)
            queue_beat(hdr[i], i == 0);
    endtask

    function automatic logic [iprx_pkg::ADDR_W-1:0] pick_destination();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return local_addr_model;
            4, 5:       return iprx_pkg::BCAST_ADDRESS;
            6:          return local_addr_model ^ (32'h1 << $urandom_range(0, 31));
            default:    return 32'($urandom);
        endcase
    endfunction

    function automatic logic [iprx_pkg::PROTO_W-1:0] pick_protocol();
        case ($urandom_range(0, 3))
            0:       return iprx_pkg::PROTO_ICMP;
            1:       return iprx_pkg::PROTO_UDP;
            2:       return iprx_pkg::PROTO_TCP;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic queue_traffic(input int count);
        int queued;
        int r;
        int n;
        logic [iprx_pkg::NIB_W-1:0] ihl;
        logic [iprx_pkg::NIB_W-1:0] version;
        queued = 0;
        while (queued < count)
        begin
            r       = $urandom_range(0, 99);
            ihl     = ($urandom_range(0, 9) < 7) ? iprx_pkg::MIN_IHL
                                                 : 4'($urandom_range(6, 15));
            version = ($urandom_range(0, 19) == 0) ? 4'($urandom) : iprx_pkg::IP_VERSION;
            if (r < 78)
            begin
                queue_header(version, ihl, pick_protocol(), pick_destination(),
                             $urandom_range(0, 9) != 0, int'(ihl) * 2);
                queued += int'(ihl) * 2;
                n = $urandom_range(0, 3);
                repeat (n)
                    queue_beat(16'($urandom), 1'b0);
                queued += n;
            end
            else if (r < 88)
            begin
                n = $urandom_range(1, int'(ihl) * 2 - 1);
                queue_header(version, ihl, pick_protocol(), pick_destination(), 1'b1, n);
                queued += n;
            end
            else if (r < 94)
            begin
                queue_beat({4'($urandom), 4'($urandom_range(0, 4)), 8'($urandom)}, 1'b1);
                queued++;
            end
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    queue_beat(16'($urandom), 1'($urandom));
                queued += n;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || words_if.valid)
            @(posedge clk);
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_local_address(input logic [iprx_pkg::ADDR_W-1:0] addr);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= addr;
        @(posedge clk);
        cfg_we    <= 1'b0;
        local_addr_model = addr;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            words_if.valid <= 1'b0;
            send_gap = 0;
        end
        else if (!words_if.valid || words_if.ready)
        begin
            if (send_gap > 0)
            begin
                words_if.valid <= 1'b0;
                send_gap--;
            end
            else if (pending_words.size() != 0)
            begin
                words_if.valid       <= 1'b1;
                words_if.header_word <= pending_words[0].header_word;
                words_if.first_word  <= pending_words[0].first_word;
                void'(pending_words.pop_front());
                send_gap = next_gap();
            end
            else
                words_if.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            verdicts_if.ready <= 1'b0;
            recv_stall = 0;
            hold_left = 0;
        end
        else if (hold_left > 0)
        begin
            verdicts_if.ready <= 1'b0;
            hold_left--;
        end
        else if (long_hold_done != long_hold_asked)
        begin
            verdicts_if.ready <= 1'b0;
            long_hold_done++;
            hold_left = LONG_HOLD;
        end
        else if (recv_stall > 0)
        begin
            verdicts_if.ready <= 1'b0;
            recv_stall--;
        end
        else
        begin
            verdicts_if.ready <= 1'b1;
            recv_stall = next_gap();
        end
    end

    always @(posedge clk)
    begin
        iprx_pkg::word_beat_t beat;
        if (rst_n && words_if.valid && words_if.ready)
        begin
            beat.header_word = words_if.header_word;
            beat.first_word  = words_if.first_word;
            filter_word(beat);
        end
    end

    always @(posedge clk)
    begin
        iprx_pkg::result_t want;
        if (rst_n && verdicts_if.valid && verdicts_if.ready)
        begin
            if (expected_verdicts.size() == 0)
                report_mismatch($sformatf("unexpected verdict beat %0d",
                                          verdicts_if.verdict));
            else
            begin
                want = expected_verdicts.pop_front();
                if (verdicts_if.verdict !== want.verdict)
                    report_mismatch($sformatf("verdict %0d, expected %0d",
                                              verdicts_if.verdict, want.verdict));
                if (verdicts_if.total_length !== want.total_length)
                    report_mismatch($sformatf("total_length %h, expected %h",
                                              verdicts_if.total_length, want.total_length));
                if (verdicts_if.protocol_number !== want.protocol_number)
                    report_mismatch($sformatf("protocol_number %h, expected %h",
                                              verdicts_if.protocol_number,
                                              want.protocol_number));
            end
        end
    end

    initial
    begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        words_if.valid       = 1'b0;
        words_if.header_word = '0;
        words_if.first_word  = 1'b0;
        verdicts_if.ready    = 1'b0;
        local_addr_model     = iprx_pkg::LOCAL_ADDRESS_RESET;
        parsing              = 1'b0;
        parse_count          = '0;
        parse_words          = '0;
        csum_acc             = '0;
        version_nib          = '0;
        length_seen          = '0;
        proto_seen           = '0;
        dest_seen            = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // A stray word while idle, short header lengths, a cut-off header and a clean one.
        queue_beat(16'hFFFF, 1'b0);
        queue_beat(16'h0000, 1'b1);
        queue_beat(16'hF4FF, 1'b1);
        queue_header(iprx_pkg::IP_VERSION, iprx_pkg::MIN_IHL, iprx_pkg::PROTO_TCP,
                     iprx_pkg::BCAST_ADDRESS, 1'b1, 3);
        queue_header(iprx_pkg::IP_VERSION, iprx_pkg::MIN_IHL, iprx_pkg::PROTO_UDP,
                     local_addr_model, 1'b1, 10);
        queue_beat(16'hFFFF, 1'b0);
        queue_beat(16'h0000, 1'b0);
        wait_drained();

        // No idling on either side, and the receiver holds off long enough to back up the input.
        steady = 1'b1;
        long_hold_asked++;
        queue_traffic(PHASE_WORDS);
        wait_drained();
        steady = 1'b0;

        write_local_address(32'h0000_0000);
        queue_traffic(PHASE_WORDS);
        wait_drained();
        write_local_address(32'hFFFF_FFFF);
        queue_traffic(PHASE_WORDS);
        wait_drained();
        write_local_address(32'($urandom));
        queue_traffic(PHASE_WORDS);
        wait_drained();
        write_local_address(32'h0A00_0001);
        queue_traffic(PHASE_WORDS);
        wait_drained();
        write_local_address(32'($urandom));
        queue_traffic(PHASE_WORDS);
        wait_drained();

        repeat (8) @(posedge clk);
        if (expected_verdicts.size() != 0)
            report_mismatch($sformatf("%0d verdicts never arrived", expected_verdicts.size()));
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
src/iprx_pkg.sv
src/iprx_word_if.sv
src/iprx_verdict_if.sv
src/iprx_in_stage.sv
src/iprx_hdr_parse.sv
src/iprx_out_stage.sv
src/ipv4_rx_header_filter.sv
tb/tb_top.sv
